// ----- rtl/core/bba_pkg.sv -----
package bba_pkg;

  localparam int unsigned MaxBlocksDef   = 65536;
  localparam int unsigned MapWordBitsDef = 32;

  localparam int unsigned CmdW = 2;
  localparam int unsigned BlkW = 16;
  localparam int unsigned TotW = 17;

  localparam int unsigned TotMax     = (1 << TotW) - 1;
  localparam int unsigned ResetTotal = 65536;

  typedef enum logic [CmdW-1:0] {
    CmdAlloc   = 2'd0,
    CmdRelease = 2'd1,
    CmdRead    = 2'd2,
    CmdWrite   = 2'd3
  } cmd_e;

  // leading zero count of a 64-bit word, 64 when the word is zero
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [63:0] x;
    logic [6:0]  cnt;
    int unsigned s;
    x   = v;
    cnt = '0;
    if (v == '0) begin
      cnt = 7'd64;
    end else begin
      for (s = 32; s >= 1; s = s / 2) begin
        if ((x & ~(64'hFFFF_FFFF_FFFF_FFFF >> s)) == '0) begin
          cnt = cnt + 7'(s);
          x   = x << s;
        end
      end
    end
    return cnt;
  endfunction

endpackage

// ----- rtl/core/bba_ram.sv -----
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bitmap_block_allocator_top.sv -----
// First-fit block allocator over an occupancy bitmap (one bit per block, 1 = used)
// held in a simple dual-port RAM of MAP_WORD_BITS-wide words, plus a free count.
// Input channel: in_valid_i / in_stall_o carry command_i, block_number_i and
// bit_value_i; a transaction is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry result_block_o, read_bit_o,
// status_o and free_left_o, one result transaction per command.
// Config: cfg_we_i writes total_blocks from cfg_wdata_i and reloads the free count
// with min(total_blocks, MAX_BLOCKS); the bitmap is kept.
// Steps to result valid: release, read and write go through divide, split,
// read-modify-write and result; allocate does a memory read, then a first-free
// search, per bitmap word scanned, then the bit set and result; a failed allocate
// on an empty count goes straight to result. One command is in flight at a time;
// the next is taken as soon as the previous result sits in the output register.
// Reset clears the control state, loads total_blocks with 65536 and runs a
// clearing pass over the bitmap RAM, one word a cycle, during which in_stall_o
// stays high.
// When the receiver stalls, the result holds in the output register and a new
// result waits in the block until the register frees up.
module bitmap_block_allocator_top import bba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS    = MaxBlocksDef,
  parameter int unsigned MAP_WORD_BITS = MapWordBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [CmdW-1:0] command_i,
  input  logic [BlkW-1:0] block_number_i,
  input  logic            bit_value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [BlkW-1:0] result_block_o,
  output logic            read_bit_o,
  output logic            status_o,
  output logic [TotW-1:0] free_left_o,
  input  logic            cfg_we_i,
  input  logic [TotW-1:0] cfg_wdata_i
);

  localparam int unsigned Depth    = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned BitW     = $clog2(MAP_WORD_BITS);
  localparam int unsigned DivShift = BlkW + BitW;
  localparam int unsigned DivMul   = ((1 << DivShift) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned ProdW    = BlkW + DivShift + 1;
  localparam int unsigned BaseW    = TotW + 1;
  localparam int unsigned LimCap   = (MAX_BLOCKS < TotMax) ? MAX_BLOCKS : TotMax;
  localparam int unsigned ResetLim = (ResetTotal < LimCap) ? ResetTotal : LimCap;

  localparam logic [TotW-1:0]  LimCapV   = TotW'(LimCap);
  localparam logic [BitW-1:0]  TopBit    = BitW'(MAP_WORD_BITS - 1);
  localparam logic [AddrW-1:0] LastWord  = AddrW'(Depth - 1);

  typedef enum logic [8:0] {
    StClear   = 9'b000000001,
    StIdle    = 9'b000000010,
    StDiv     = 9'b000000100,
    StSplit   = 9'b000001000,
    StMod     = 9'b000010000,
    StScanRd  = 9'b000100000,
    StScanChk = 9'b001000000,
    StAlloc   = 9'b010000000,
    StDone    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0] clr_q, clr_d;
  cmd_e             cmd_q, cmd_d;
  logic [BlkW-1:0]  blk_q, blk_d;
  logic             val_q, val_d;
  logic [BlkW-1:0]  quo_q, quo_d;
  logic [BitW-1:0]  rem_q, rem_d;
  logic             inrng_q, inrng_d;
  logic [AddrW-1:0] wrd_q, wrd_d;
  logic [BaseW-1:0] base_q, base_d;
  logic [BitW-1:0]  pos_q, pos_d;
  logic [BlkW-1:0]  res_blk_q, res_blk_d;
  logic             res_bit_q, res_bit_d;
  logic             res_stat_q, res_stat_d;
  logic             out_valid_q, out_valid_d;
  logic [BlkW-1:0]  out_blk_q, out_blk_d;
  logic             out_bit_q, out_bit_d;
  logic             out_stat_q, out_stat_d;
  logic [TotW-1:0]  out_free_q, out_free_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [TotW-1:0]  lim_q, lim_d;
  logic [TotW-1:0]  free_q, free_d;

  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata;
  logic                     ram_re;
  logic [AddrW-1:0]         ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_rdata;

  logic                     slot_free;
  logic [ProdW-1:0]         prod;
  logic [BlkW-1:0]          quo_scaled;
  logic [BitW-1:0]          bix;
  logic [BitW-1:0]          alloc_bix;
  logic [MAP_WORD_BITS-1:0] bit_mask;
  logic [MAP_WORD_BITS-1:0] alloc_mask;
  logic [BaseW-1:0]         room;
  logic [MAP_WORD_BITS-1:0] avail;
  logic [6:0]               lz;

  bba_ram #(
    .WIDTH(MAP_WORD_BITS),
    .DEPTH(Depth)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign prod       = ProdW'(blk_q) * ProdW'(DivMul);
  assign quo_scaled = BlkW'(32'(quo_q) * 32'(MAP_WORD_BITS));
  assign bix        = TopBit - rem_q;
  assign alloc_bix  = TopBit - pos_q;
  assign bit_mask   = MAP_WORD_BITS'(1) << bix;
  assign alloc_mask = MAP_WORD_BITS'(1) << alloc_bix;
  assign room       = {1'b0, lim_q} - base_q;

  always_comb begin
    for (int k = 0; k < MAP_WORD_BITS; k++) begin
      avail[MAP_WORD_BITS-1-k] = !ram_rdata[MAP_WORD_BITS-1-k] && (BaseW'(k) < room);
    end
  end

  assign lz = lzc64(64'(avail) << (64 - MAP_WORD_BITS));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    blk_d       = blk_q;
    val_d       = val_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    inrng_d     = inrng_q;
    wrd_d       = wrd_q;
    base_d      = base_q;
    pos_d       = pos_q;
    res_blk_d   = res_blk_q;
    res_bit_d   = res_bit_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_blk_d   = out_blk_q;
    out_bit_d   = out_bit_q;
    out_stat_d  = out_stat_q;
    out_free_d  = out_free_q;
    total_d     = total_q;
    lim_d       = lim_q;
    free_d      = free_q;
    ram_we      = 1'b0;
    ram_waddr   = AddrW'(quo_q);
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = AddrW'(quo_q);

    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastWord) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_d      = cmd_e'(command_i);
          blk_d      = block_number_i;
          val_d      = bit_value_i;
          wrd_d      = '0;
          base_d     = '0;
          res_blk_d  = '0;
          res_bit_d  = 1'b0;
          res_stat_d = 1'b0;
          if (cmd_e'(command_i) != CmdAlloc) begin
            state_d = StDiv;
          end else if (free_q == '0) begin
            res_stat_d = 1'b1;
            state_d    = StDone;
          end else begin
            state_d = StScanRd;
          end
        end
      end
      StDiv: begin
        quo_d   = BlkW'(prod >> DivShift);
        state_d = StSplit;
      end
      StSplit: begin
        rem_d   = BitW'(blk_q - quo_scaled);
        inrng_d = {1'b0, blk_q} < lim_q;
        ram_re  = {1'b0, blk_q} < lim_q;
        state_d = StMod;
      end
      StMod: begin
        case (cmd_q)
          CmdRelease: begin
            res_blk_d = blk_q;
            if (inrng_q) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~bit_mask;
              if (free_q < lim_q) begin
                free_d = free_q + 1'b1;
              end
            end
          end
          CmdRead: begin
            res_bit_d = inrng_q && ram_rdata[bix];
          end
          CmdWrite: begin
            if (inrng_q) begin
              ram_we    = 1'b1;
              ram_wdata = val_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
            end
          end
          default: begin
            res_stat_d = 1'b1;
          end
        endcase
        state_d = StDone;
      end
      StScanRd: begin
        if (base_q >= {1'b0, lim_q}) begin
          res_stat_d = 1'b1;
          state_d    = StDone;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wrd_q;
          state_d   = StScanChk;
        end
      end
      StScanChk: begin
        if (avail != '0) begin
          pos_d   = BitW'(lz);
          state_d = StAlloc;
        end else begin
          wrd_d   = wrd_q + 1'b1;
          base_d  = base_q + BaseW'(MAP_WORD_BITS);
          state_d = StScanRd;
        end
      end
      StAlloc: begin
        ram_we    = 1'b1;
        ram_waddr = wrd_q;
        ram_wdata = ram_rdata | alloc_mask;
        res_blk_d = BlkW'(base_q + BaseW'(pos_q));
        if (free_q != '0) begin
          free_d = free_q - 1'b1;
        end
        state_d = StDone;
      end
      StDone: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_blk_d   = res_blk_q;
          out_bit_d   = res_bit_q;
          out_stat_d  = res_stat_q;
          out_free_d  = free_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
      lim_d   = (cfg_wdata_i < LimCapV) ? cfg_wdata_i : LimCapV;
      free_d  = (cfg_wdata_i < LimCapV) ? cfg_wdata_i : LimCapV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      total_q     <= TotW'(ResetTotal);
      lim_q       <= TotW'(ResetLim);
      free_q      <= TotW'(ResetLim);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      lim_q       <= lim_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    blk_q      <= blk_d;
    val_q      <= val_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    inrng_q    <= inrng_d;
    wrd_q      <= wrd_d;
    base_q     <= base_d;
    pos_q      <= pos_d;
    res_blk_q  <= res_blk_d;
    res_bit_q  <= res_bit_d;
    res_stat_q <= res_stat_d;
    out_blk_q  <= out_blk_d;
    out_bit_q  <= out_bit_d;
    out_stat_q <= out_stat_d;
    out_free_q <= out_free_d;
  end

  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = out_valid_q;
  assign result_block_o = out_blk_q;
  assign read_bit_o     = out_bit_q;
  assign status_o       = out_stat_q;
  assign free_left_o    = out_free_q;

  // free count never passes the effective limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= lim_q)
    else $error("free count above block limit");

  // a successful allocate takes exactly one block from the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAlloc && !cfg_we_i && free_q != '0) |=> free_q == $past(free_q) - 1'b1)
    else $error("allocate did not decrement free count");

  // a failed allocate carries no block number and no bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (result_block_o == '0 && !read_bit_o))
    else $error("no-free result carries payload");

  // total_blocks register and limit move together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lim_q <= total_q)
    else $error("limit above total_blocks");

endmodule
